// File: rtl/i2c_master_three_byte_write_core_assert.svh
// Assertion macros shared by the I2C three-byte write core.
`ifndef I2C_MASTER_THREE_BYTE_WRITE_CORE_ASSERT_SVH
`define I2C_MASTER_THREE_BYTE_WRITE_CORE_ASSERT_SVH

// A condition that must hold in the same cycle as its trigger.
`define I2CM3W_ASSERT_NOW(label, clock, reset_n, trig, cond) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (trig) |-> (cond)) \
        else $error("i2cm3w assertion failed");

// A condition that must hold in the cycle after its trigger.
`define I2CM3W_ASSERT_NEXT(label, clock, reset_n, trig, cond) \
    label: assert property (@(posedge clock) disable iff (!reset_n) (trig) |=> (cond)) \
        else $error("i2cm3w assertion failed");

`endif

// File: rtl/i2cm3w_pkg.sv
// Package with types and constants of the I2C three-byte write core.
package i2cm3w_pkg;

    localparam int unsigned DELAY_COUNT_WIDTH_DEF = 16;
    localparam int unsigned TICKS_WIDTH           = 16;
    localparam logic [TICKS_WIDTH-1:0] TICKS_RESET = 16'd1000;
    localparam logic [2:0] LAST_BIT  = 3'd7;
    localparam logic [1:0] LAST_BYTE = 2'd2;
    localparam logic [1:0] FIRST_DATA_INDEX = 2'd1;

    typedef enum logic [10:0] {
        PH_IDLE     = 11'b000_0000_0001,
        PH_START_A  = 11'b000_0000_0010,
        PH_START_B  = 11'b000_0000_0100,
        PH_START_C  = 11'b000_0000_1000,
        PH_BIT_LOW  = 11'b000_0001_0000,
        PH_BIT_HIGH = 11'b000_0010_0000,
        PH_ACK_PRE  = 11'b000_0100_0000,
        PH_ACK_HIGH = 11'b000_1000_0000,
        PH_STOP_A   = 11'b001_0000_0000,
        PH_STOP_B   = 11'b010_0000_0000,
        PH_STOP_C   = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  bit_count;
        logic [1:0]  byte_index;
        logic [7:0]  shift_byte;
        logic [15:0] held_bytes;
        logic        scl_out;
        logic        sda_out;
        logic        nack_seen;
    } seq_state_t;

    typedef struct packed {
        logic ok;
        logic done_res;
        logic busy_res;
        logic sda_level;
        logic scl_level;
    } result_t;

endpackage

// File: rtl/i2cm3w_step.sv
// Next-state and result logic for one item of the I2C three-byte write core.
module i2cm3w_step
    import i2cm3w_pkg::*;
#(
    parameter int unsigned DELAY_COUNT_WIDTH = DELAY_COUNT_WIDTH_DEF
)
(
    input  logic [TICKS_WIDTH-1:0]       ticks_per_delay,
    input  logic                         mode,
    input  logic [7:0]                   device_byte,
    input  logic [7:0]                   first_data,
    input  logic [7:0]                   second_data,
    input  logic                         sda_in,
    input  seq_state_t                   state_cur,
    input  logic [DELAY_COUNT_WIDTH-1:0] delay_cur,
    output seq_state_t                   state_next,
    output logic [DELAY_COUNT_WIDTH-1:0] delay_next,
    output result_t                      res
);

    logic [DELAY_COUNT_WIDTH-1:0] delay_trunc;
    logic [DELAY_COUNT_WIDTH-1:0] delay_load;
    logic                         done;

    assign delay_trunc = DELAY_COUNT_WIDTH'(ticks_per_delay);
    assign delay_load  = (delay_trunc == '0) ? DELAY_COUNT_WIDTH'(1) : delay_trunc;

    always_comb
    begin
        state_next = state_cur;
        delay_next = delay_cur;
        done       = 1'b0;
        if (mode)
        begin
            if (state_cur.phase == PH_IDLE)
            begin
                state_next.shift_byte = device_byte;
                state_next.held_bytes = {first_data, second_data};
                state_next.bit_count  = '0;
                state_next.byte_index = '0;
                state_next.nack_seen  = 1'b0;
                state_next.sda_out    = 1'b1;
                state_next.phase      = PH_START_A;
                delay_next            = delay_load;
            end
        end
        else if (state_cur.phase != PH_IDLE)
        begin
            if (delay_cur > DELAY_COUNT_WIDTH'(1))
            begin
                delay_next = delay_cur - DELAY_COUNT_WIDTH'(1);
            end
            else
            begin
                delay_next = delay_load;
                case (state_cur.phase)
                    PH_START_A:
                    begin
                        state_next.scl_out = 1'b1;
                        state_next.phase   = PH_START_B;
                    end
                    PH_START_B:
                    begin
                        state_next.sda_out = 1'b0;
                        state_next.phase   = PH_START_C;
                    end
                    PH_START_C:
                    begin
                        state_next.scl_out = 1'b0;
                        state_next.sda_out = state_cur.shift_byte[7];
                        state_next.phase   = PH_BIT_LOW;
                    end
                    PH_BIT_LOW:
                    begin
                        state_next.scl_out = 1'b1;
                        state_next.phase   = PH_BIT_HIGH;
                    end
                    PH_BIT_HIGH:
                    begin
                        state_next.scl_out = 1'b0;
                        if (state_cur.bit_count < LAST_BIT)
                        begin
                            state_next.bit_count  = state_cur.bit_count + 3'd1;
                            state_next.shift_byte = {state_cur.shift_byte[6:0], 1'b0};
                            state_next.sda_out    = state_cur.shift_byte[6];
                            state_next.phase      = PH_BIT_LOW;
                        end
                        else
                        begin
                            state_next.phase = PH_ACK_PRE;
                        end
                    end
                    PH_ACK_PRE:
                    begin
                        state_next.scl_out = 1'b1;
                        state_next.sda_out = 1'b1;
                        state_next.phase   = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH:
                    begin
                        state_next.scl_out = 1'b0;
                        if (sda_in)
                        begin
                            state_next.nack_seen = 1'b1;
                            state_next.sda_out   = 1'b0;
                            state_next.phase     = PH_STOP_A;
                        end
                        else if (state_cur.byte_index < LAST_BYTE)
                        begin
                            state_next.byte_index = state_cur.byte_index + 2'd1;
                            state_next.shift_byte =
                                (state_cur.byte_index + 2'd1 == FIRST_DATA_INDEX)
                                ? state_cur.held_bytes[15:8] : state_cur.held_bytes[7:0];
                            state_next.sda_out    =
                                (state_cur.byte_index + 2'd1 == FIRST_DATA_INDEX)
                                ? state_cur.held_bytes[15] : state_cur.held_bytes[7];
                            state_next.bit_count  = '0;
                            state_next.phase      = PH_BIT_LOW;
                        end
                        else
                        begin
                            state_next.sda_out = 1'b0;
                            state_next.phase   = PH_STOP_A;
                        end
                    end
                    PH_STOP_A:
                    begin
                        state_next.scl_out = 1'b1;
                        state_next.phase   = PH_STOP_B;
                    end
                    PH_STOP_B:
                    begin
                        state_next.sda_out = 1'b1;
                        state_next.phase   = PH_STOP_C;
                    end
                    default:
                    begin
                        // The last delay of the stop condition has run out.
                        state_next.phase = PH_IDLE;
                        delay_next       = '0;
                        done             = 1'b1;
                    end
                endcase
            end
        end
    end

    assign res.scl_level = state_next.scl_out;
    assign res.sda_level = state_next.sda_out;
    assign res.busy_res  = (state_next.phase != PH_IDLE);
    assign res.done_res  = done;
    assign res.ok        = done & ~state_next.nack_seen;

endmodule

// File: rtl/i2c_master_three_byte_write_core.sv
// Top level of the I2C master core that writes a device byte and two data bytes.
//
// An input item on the s_ group either launches a write (tuser = 1) or is one
// tick of time (tuser = 0). A launch loads the three bytes while idle and is
// ignored while busy. Ticks step the SCL/SDA pin sequence, one pin change per
// ticks_per_delay ticks: start, three bytes MSB first each with an acknowledge
// slot, then stop. A NACK ends the write early with a stop and ok low.
// Every input item yields exactly one result item on the m_ group carrying
// the pin levels, busy, a done pulse and ok.
// ticks_per_delay is written through cfg_we/cfg_data; the user must do so only
// while the core is idle, which the core does not enforce. An accepted item
// sits in the input register; the step logic then updates the sequencer state
// and loads the result register once that register is empty or m_tready is
// high. Throughput is one item per cycle while m_tready is high, set by the
// state update loop. When m_tready is low with a result waiting, the result
// register holds and the input register takes at most one more item before
// s_tready drops. Reset puts the sequencer in idle with SCL and SDA released
// and ticks_per_delay at 1000; both registers come up empty.
`include "i2c_master_three_byte_write_core_assert.svh"

module i2c_master_three_byte_write_core
    import i2cm3w_pkg::*;
#(
    parameter int unsigned DELAY_COUNT_WIDTH = DELAY_COUNT_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [TICKS_WIDTH-1:0] cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // device_byte[7:0], first_data[15:8], second_data[23:16], sda_in[24], zeros
    input  logic [31:0]            s_tdata,
    // mode[0]
    input  logic                   s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // scl_level[0], sda_level[1], busy_res[2], done_res[3], ok[4], zeros
    output logic [7:0]             m_tdata
);

    logic [TICKS_WIDTH-1:0]       ticks_reg;
    logic                         in_valid_reg;
    logic                         in_mode_reg;
    logic [24:0]                  in_data_reg;
    seq_state_t                   state_reg;
    seq_state_t                   state_next;
    logic [DELAY_COUNT_WIDTH-1:0] delay_reg;
    logic [DELAY_COUNT_WIDTH-1:0] delay_next;
    logic                         out_valid_reg;
    result_t                      out_res_reg;
    result_t                      res_next;
    logic                         advance;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg};

    i2cm3w_step #(
        .DELAY_COUNT_WIDTH(DELAY_COUNT_WIDTH)
    ) u_step (
        .ticks_per_delay(ticks_reg),
        .mode           (in_mode_reg),
        .device_byte    (in_data_reg[7:0]),
        .first_data     (in_data_reg[15:8]),
        .second_data    (in_data_reg[23:16]),
        .sda_in         (in_data_reg[24]),
        .state_cur      (state_reg),
        .delay_cur      (delay_reg),
        .state_next     (state_next),
        .delay_next     (delay_next),
        .res            (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg            <= TICKS_RESET;
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.phase      <= PH_IDLE;
            state_reg.bit_count  <= '0;
            state_reg.byte_index <= '0;
            state_reg.shift_byte <= '0;
            state_reg.held_bytes <= '0;
            state_reg.scl_out    <= 1'b1;
            state_reg.sda_out    <= 1'b1;
            state_reg.nack_seen  <= 1'b0;
            delay_reg            <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                ticks_reg <= cfg_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                delay_reg     <= delay_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_mode_reg <= s_tuser;
            in_data_reg <= s_tdata[24:0];
        end
        if (advance)
        begin
            out_res_reg <= res_next;
        end
    end

    `I2CM3W_ASSERT_NOW(a_done_not_busy, clk, rst_n,
        out_valid_reg && out_res_reg.done_res, !out_res_reg.busy_res)
    `I2CM3W_ASSERT_NOW(a_ok_needs_done, clk, rst_n,
        out_valid_reg && out_res_reg.ok, out_res_reg.done_res)
    `I2CM3W_ASSERT_NOW(a_delay_tracks_busy, clk, rst_n,
        1'b1, (state_reg.phase == PH_IDLE) == (delay_reg == '0))
    `I2CM3W_ASSERT_NEXT(a_input_held, clk, rst_n,
        in_valid_reg && !advance, in_valid_reg && $stable(in_data_reg))

endmodule
